// ===== rtl/neighbor_table_best_parent_macros.svh =====
// assertion macros for the neighbor table block
`ifndef NEIGHBOR_TABLE_BEST_PARENT_MACROS_SVH
`define NEIGHBOR_TABLE_BEST_PARENT_MACROS_SVH

`ifndef SYNTHESIS
// checked at every rising aclk edge outside reset
`define NTBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked at every rising aclk edge, reset included
`define NTBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define NTBP_ASSERT(label, prop, msg)
`define NTBP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/ntbp_pkg.sv =====
`timescale 1ns / 1ps

package ntbp_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0]        EMPTY_ADDR = 32'hFFFF_FFFF;
    localparam logic signed [7:0]  RSSI_FLOOR = -8'sd127;
    localparam logic [7:0]         HOPS_EMPTY = 8'hFF;
    localparam int                 HOPS_LIMIT = 8;
    localparam int                 FEW_W      = $clog2(HOPS_LIMIT + 1);
    localparam logic signed [7:0]  THR_RESET  = -8'sd80;

    // request kinds on tuser
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // insert outcome
    localparam logic [1:0] STATUS_UPDATED = 2'd0;
    localparam logic [1:0] STATUS_ADDED   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [31:0]       addr;
        logic signed [7:0] rssi;
        logic [7:0]        hops;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{addr: EMPTY_ADDR, rssi: RSSI_FLOOR, hops: HOPS_EMPTY};

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_idx;
        logic             clr;
    } tbl_req_t;

endpackage

// ===== rtl/ntbp_table.sv =====
`timescale 1ns / 1ps

// neighbor storage, one write and one registered read per cycle
module ntbp_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  ntbp_pkg::tbl_req_t req,
    output ntbp_pkg::entry_t  rd_entry
);

    ntbp_pkg::entry_t                       mem [ntbp_pkg::TABLE_DEPTH];
    logic [ntbp_pkg::TABLE_DEPTH-1:0]       vld_reg;
    ntbp_pkg::entry_t                       rd_data_reg;
    logic                                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_idx] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_idx];
    end

    // per-entry valid, an entry never written reads as the empty pattern
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[req.rd_idx];
            if (req.clr) begin
                vld_reg <= '0;
            end else if (req.wr_en) begin
                vld_reg[req.wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : ntbp_pkg::RESET_ENTRY;

endmodule

// ===== rtl/neighbor_table_best_parent.sv =====
`timescale 1ns / 1ps

// channel   | ports                 | payload
// ----------+-----------------------+---------------------------------------------
// request   | s_tvalid/s_tready     | tuser: func; tdata: addr, rssi, hops, min_hops
// result    | m_tvalid/m_tready     | tdata: status, found, best_addr, best_hops
// threshold | cfg_we/cfg_wdata      | signed rssi threshold, no read-back
//
// one request at a time, s_tready high only while idle; a shared compare unit walks
// the 16-entry table one entry per cycle through a registered read port
// an insert stops its walk on a matching address; a query walks the table a second
// time when the strongest signal beats the threshold; clear and unknown skip the walk
// a waiting result never blocks a new request, only the loading of the next result
// reset empties the table at once through per-entry valid bits, threshold -80
module neighbor_table_best_parent (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_addr, entry_rssi, entry_hops, min_hops
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status, found, best_addr, best_hops, zero pad
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // rssi_threshold, signed
);

`include "neighbor_table_best_parent_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_QRY1 = 3'd2;
    localparam logic [2:0] ST_QRY2 = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int IW = ntbp_pkg::IDX_W;
    localparam int CW = ntbp_pkg::CNT_W;
    localparam int FW = ntbp_pkg::FEW_W;

    localparam logic [CW-1:0] CNT_END = CW'(ntbp_pkg::TABLE_DEPTH);

    logic [2:0]  state_reg, state_next;

    // latched request
    logic [1:0]        func_reg, func_next;
    logic [31:0]       addr_reg, addr_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic [7:0]        hops_reg, hops_next;
    logic [7:0]        minh_reg, minh_next;

    // scan pointer and read pipeline tag
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ev_vld_reg, ev_vld_next;
    logic [IW-1:0] ev_idx_reg, ev_idx_next;

    // working state
    logic              empty_found_reg, empty_found_next;
    logic [IW-1:0]     empty_idx_reg, empty_idx_next;
    logic [1:0]        status_reg, status_next;
    logic signed [7:0] best_reg, best_next;
    logic [FW-1:0]     fewest_reg, fewest_next;
    logic [31:0]       pick_addr_reg, pick_addr_next;
    logic [7:0]        pick_hops_reg, pick_hops_next;

    // threshold register
    logic signed [7:0] thr_reg;

    // result register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_found_reg, out_found_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_hops_reg, out_hops_next;

    ntbp_pkg::tbl_req_t tbl_req;
    ntbp_pkg::entry_t   rd_entry;

    logic              scanning;
    logic              issue;
    logic              scan_end;
    logic              qual;
    logic signed [7:0] cmp_rhs;
    logic              rssi_gt;
    logic              addr_hit;
    logic              addr_empty;
    logic              fewer_hops;

    ntbp_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tbl_req),
        .rd_entry (rd_entry)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_hops_reg, out_addr_reg, out_found_reg, out_status_reg};

    // scan bookkeeping: issue one read per cycle, evaluate it in the following cycle
    assign scanning = state_reg inside {ST_INS, ST_QRY1, ST_QRY2};
    assign issue    = scanning && (cnt_reg < CNT_END);
    assign scan_end = scanning && !issue && !ev_vld_reg;

    // shared compare unit: rssi against running best (first pass) or threshold
    assign cmp_rhs    = (state_reg == ST_QRY2) ? thr_reg : best_reg;
    assign rssi_gt    = $signed(rd_entry.rssi) > cmp_rhs;
    assign qual       = rd_entry.hops >= minh_reg;
    assign fewer_hops = rd_entry.hops < {{(8-FW){1'b0}}, fewest_reg};
    assign addr_hit   = rd_entry.addr == addr_reg;
    assign addr_empty = rd_entry.addr == ntbp_pkg::EMPTY_ADDR;

    always_comb begin
        state_next       = state_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        rssi_next        = rssi_reg;
        hops_next        = hops_reg;
        minh_next        = minh_reg;
        cnt_next         = cnt_reg;
        ev_vld_next      = issue;
        ev_idx_next      = cnt_reg[IW-1:0];
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        status_next      = status_reg;
        best_next        = best_reg;
        fewest_next      = fewest_reg;
        pick_addr_next   = pick_addr_reg;
        pick_hops_next   = pick_hops_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_addr_next    = out_addr_reg;
        out_hops_next    = out_hops_reg;

        tbl_req         = '0;
        tbl_req.rd_idx  = cnt_reg[IW-1:0];
        tbl_req.wr_data = '{addr: addr_reg, rssi: rssi_reg, hops: hops_reg};

        if (issue) begin
            cnt_next = cnt_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next        = s_tuser;
                    addr_next        = s_tdata[31:0];
                    rssi_next        = s_tdata[39:32];
                    hops_next        = s_tdata[47:40];
                    minh_next        = s_tdata[55:48];
                    cnt_next         = '0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    status_next      = ntbp_pkg::STATUS_FULL;
                    best_next        = ntbp_pkg::RSSI_FLOOR;
                    fewest_next      = FW'(ntbp_pkg::HOPS_LIMIT);
                    pick_addr_next   = '0;
                    pick_hops_next   = '0;
                    case (s_tuser)
                        ntbp_pkg::FUNC_INSERT: state_next = ST_INS;
                        ntbp_pkg::FUNC_QUERY:  state_next = ST_QRY1;
                        ntbp_pkg::FUNC_CLEAR: begin
                            tbl_req.clr = 1'b1;
                            state_next  = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS: begin
                if (ev_vld_reg) begin
                    if (addr_hit) begin
                        // matching address: refresh rssi and hops in place
                        tbl_req.wr_en  = 1'b1;
                        tbl_req.wr_idx = ev_idx_reg;
                        status_next    = ntbp_pkg::STATUS_UPDATED;
                        ev_vld_next    = 1'b0;
                        state_next     = ST_DONE;
                    end else if (addr_empty && !empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = ev_idx_reg;
                    end
                end
                if (scan_end) begin
                    if (empty_found_reg) begin
                        tbl_req.wr_en  = 1'b1;
                        tbl_req.wr_idx = empty_idx_reg;
                        status_next    = ntbp_pkg::STATUS_ADDED;
                    end else begin
                        status_next    = ntbp_pkg::STATUS_FULL;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_QRY1: begin
                if (ev_vld_reg) begin
                    if (qual && rssi_gt) begin
                        best_next      = rd_entry.rssi;
                        pick_addr_next = rd_entry.addr;
                        pick_hops_next = rd_entry.hops;
                    end else if (ev_idx_reg == '0) begin
                        // default pick is entry 0
                        pick_addr_next = rd_entry.addr;
                        pick_hops_next = rd_entry.hops;
                    end
                end
                if (scan_end) begin
                    if (best_reg > thr_reg) begin
                        cnt_next   = '0;
                        state_next = ST_QRY2;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_QRY2: begin
                if (ev_vld_reg && qual && rssi_gt && fewer_hops) begin
                    fewest_next    = rd_entry.hops[FW-1:0];
                    pick_addr_next = rd_entry.addr;
                    pick_hops_next = rd_entry.hops;
                end
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = '0;
                    out_found_next  = 1'b0;
                    out_addr_next   = '0;
                    out_hops_next   = '0;
                    if (func_reg == ntbp_pkg::FUNC_INSERT) begin
                        out_status_next = status_reg;
                    end else if (func_reg == ntbp_pkg::FUNC_QUERY) begin
                        out_found_next = best_reg > ntbp_pkg::RSSI_FLOOR;
                        out_addr_next  = pick_addr_reg;
                        out_hops_next  = pick_hops_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= ntbp_pkg::THR_RESET;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ev_vld_reg   <= ev_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        addr_reg        <= addr_next;
        rssi_reg        <= rssi_next;
        hops_reg        <= hops_next;
        minh_reg        <= minh_next;
        ev_idx_reg      <= ev_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        status_reg      <= status_next;
        best_reg        <= best_next;
        fewest_reg      <= fewest_next;
        pick_addr_reg   <= pick_addr_next;
        pick_hops_reg   <= pick_hops_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_addr_reg    <= out_addr_next;
        out_hops_reg    <= out_hops_next;
    end

    // a taken request always leaves idle
    `NTBP_ASSERT(a_req_leaves_idle, s_tvalid && s_tready |=> state_reg != ST_IDLE, "stuck idle")
    // table is written only while an insert walks it
    `NTBP_ASSERT(a_write_in_insert, tbl_req.wr_en |-> state_reg == ST_INS, "stray table write")
    // second query pass only runs when the strongest signal beat the threshold
    `NTBP_ASSERT(a_pass2_guard, state_reg == ST_QRY2 |-> best_reg > thr_reg, "weak second pass")
    // a new result appears only when the sequencer finishes
    `NTBP_ASSERT(a_result_done, $rose(m_tvalid) |-> $past(state_reg) == ST_DONE, "stray result")
    // scan pointer never runs past the table
    `NTBP_ASSERT_ALWAYS(a_cnt_range, !aresetn || cnt_reg <= CNT_END, "scan pointer out of range")

endmodule
